// ===== rtl/salc_pkg.sv =====
// shared constants, types and address helpers for the cache tag store
package salc_pkg;

    localparam int NUM_WAYS       = 32;
    localparam int LINE_BYTES     = 64;
    localparam int CAPACITY_BYTES = 32768;
    localparam int ADDR_BITS      = 48;

    localparam int ADDR_W    = 48;
    localparam int SET_OUT_W = 4;
    localparam int WAY_OUT_W = 5;
    localparam int COUNT_W   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    localparam int RAW_SETS  = CAPACITY_BYTES / (LINE_BYTES * NUM_WAYS);
    localparam int SET_COUNT = (RAW_SETS > 0) ? RAW_SETS : 1;
    localparam int OFF_BITS  = floor_log2(LINE_BYTES);
    localparam int IDX_BITS  = floor_log2(SET_COUNT);
    localparam int USED_SETS = 1 << IDX_BITS;
    localparam int SET_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int TAG_RAW   = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RANK_W    = WAY_W;
    localparam int FILL_W    = $clog2(NUM_WAYS + 1);
    localparam int ROW_W     = NUM_WAYS * (TAG_W + RANK_W);

    typedef logic [SET_W-1:0]  t_set;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [FILL_W-1:0] t_fill;

    typedef struct packed {
        logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
        logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             fill_grow;
    } t_lookup;

    function automatic t_set set_of(input logic [ADDR_W-1:0] address);
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] s;
        a = ADDR_BITS'(address);
        s = (a >> OFF_BITS) & ADDR_BITS'((1 << IDX_BITS) - 1);
        return SET_W'(s);
    endfunction

    function automatic t_tag tag_of(input logic [ADDR_W-1:0] address);
        logic [ADDR_BITS-1:0] a;
        a = ADDR_BITS'(address);
        return TAG_W'(a >> (OFF_BITS + IDX_BITS));
    endfunction

endpackage

// ===== rtl/salc_ram.sv =====
// generic single write port ram with registered read
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/salc_lookup.sv =====
// tag compare, victim choice and recency update for one set row
module salc_lookup (
    input  salc_pkg::t_tag    i_tag,
    input  salc_pkg::t_row    i_row,
    input  salc_pkg::t_fill   i_fill,
    output salc_pkg::t_lookup o_res,
    output salc_pkg::t_row    o_row
);
    import salc_pkg::*;

    logic [NUM_WAYS-1:0] valid;
    logic [NUM_WAYS-1:0] match;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    victim;
    logic [WAY_W-1:0]    way;
    logic [RANK_W-1:0]   limit;
    logic                hit;
    logic                full;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            // lines fill from way 0 upward and never leave
            valid[w] = FILL_W'(w) < i_fill;
            match[w] = valid[w] && (i_row.tag[w] == i_tag);
        end

        hit_way = '0;
        victim  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (i_row.rank[w] == RANK_W'(NUM_WAYS - 1)) begin
                victim = WAY_W'(w);
            end
        end

        hit   = |match;
        full  = i_fill == FILL_W'(NUM_WAYS);
        way   = hit ? hit_way : (full ? victim : WAY_W'(i_fill));
        limit = i_row.rank[hit_way];

        o_row = i_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                o_row.rank[w] = '0;
                if (!hit) begin
                    o_row.tag[w] = i_tag;
                end
            end else if (valid[w] && (!hit || (i_row.rank[w] < limit))) begin
                o_row.rank[w] = i_row.rank[w] + RANK_W'(1);
            end
        end

        o_res.hit       = hit;
        o_res.way       = way;
        o_res.fill_grow = !hit && !full;
    end

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// top level of the set-associative cache tag store with lru replacement
// set and tag are registered, then the result word in the output register
// throughput: one address per cycle unless stalled; one set row read per word
// a word to the set written in the previous cycle takes its row from a bypass register
// reset: synchronous, clears fill counts, hit and miss totals and valid flags
module set_assoc_lru_cache_tags (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [salc_pkg::ADDR_W-1:0]    i_address,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [salc_pkg::SET_OUT_W-1:0] o_set_index,
    output logic [salc_pkg::WAY_OUT_W-1:0] o_way_index,
    output logic [salc_pkg::COUNT_W-1:0]   o_hit_total,
    output logic [salc_pkg::COUNT_W-1:0]   o_miss_total
);
    import salc_pkg::*;

    logic             w_advance;
    logic             w_accept;
    logic             w_move;

    logic             r_s1_valid;
    t_set             r_s1_set;
    t_tag             r_s1_tag;

    logic [ROW_W-1:0] w_rdata;
    t_row             w_row;
    t_row             w_new_row;
    t_lookup          w_res;

    t_fill            r_fill [USED_SETS];

    logic             r_fwd_valid;
    t_set             r_fwd_set;
    t_row             r_fwd_row;

    logic             r_out_valid;
    logic             r_out_hit;
    t_set             r_out_set;
    logic [WAY_W-1:0] r_out_way;

    logic [COUNT_W-1:0] r_hit_cnt;
    logic [COUNT_W-1:0] r_miss_cnt;
    logic [COUNT_W-1:0] n_hit_cnt;
    logic [COUNT_W-1:0] n_miss_cnt;

    assign w_advance = !(r_out_valid && i_stall);
    assign o_stall   = r_s1_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;
    assign w_move    = r_s1_valid && w_advance;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (USED_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_move),
        .i_waddr (r_s1_set),
        .i_wdata (ROW_W'(w_new_row)),
        .i_re    (w_accept),
        .i_raddr (set_of(i_address)),
        .o_rdata (w_rdata)
    );

    // bypass the row written on the same edge as this read
    assign w_row = (r_fwd_valid && (r_fwd_set == r_s1_set)) ? r_fwd_row : t_row'(w_rdata);

    salc_lookup u_lookup (
        .i_tag  (r_s1_tag),
        .i_row  (w_row),
        .i_fill (r_fill[r_s1_set]),
        .o_res  (w_res),
        .o_row  (w_new_row)
    );

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_move) begin
            if (w_res.hit) begin
                if (r_hit_cnt != COUNT_MAX) begin
                    n_hit_cnt = r_hit_cnt + COUNT_W'(1);
                end
            end else if (r_miss_cnt != COUNT_MAX) begin
                n_miss_cnt = r_miss_cnt + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            for (int s = 0; s < USED_SETS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_fwd_valid <= 1'b1;
                if (w_res.fill_grow) begin
                    r_fill[r_s1_set] <= r_fill[r_s1_set] + FILL_W'(1);
                end
            end else if (w_advance) begin
                r_out_valid <= 1'b0;
            end
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_set <= set_of(i_address);
            r_s1_tag <= tag_of(i_address);
        end
        if (w_move) begin
            r_fwd_set <= r_s1_set;
            r_fwd_row <= w_new_row;
            r_out_hit <= w_res.hit;
            r_out_set <= r_s1_set;
            r_out_way <= w_res.way;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_set_index  = SET_OUT_W'(r_out_set);
    assign o_way_index  = WAY_OUT_W'(r_out_way);
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

endmodule

// ===== rtl/salc_checker.sv =====
// port-level checker for the cache tag store, bound to the top level
module salc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [salc_pkg::ADDR_W-1:0]    i_address,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_hit,
    input logic [salc_pkg::SET_OUT_W-1:0] o_set_index,
    input logic [salc_pkg::WAY_OUT_W-1:0] o_way_index,
    input logic [salc_pkg::COUNT_W-1:0]   o_hit_total,
    input logic [salc_pkg::COUNT_W-1:0]   o_miss_total
);
    import salc_pkg::*;

    logic [COUNT_W-1:0] r_prev_hit;
    logic [COUNT_W-1:0] r_prev_miss;
    logic               w_out_acc;
    logic               w_hit_step;
    logic               w_miss_step;

    assign w_out_acc   = o_valid && !i_stall;
    assign w_hit_step  = (o_hit_total == r_prev_hit + COUNT_W'(1)) ||
                         ((r_prev_hit == COUNT_MAX) && (o_hit_total == COUNT_MAX));
    assign w_miss_step = (o_miss_total == r_prev_miss + COUNT_W'(1)) ||
                         ((r_prev_miss == COUNT_MAX) && (o_miss_total == COUNT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_hit  <= '0;
            r_prev_miss <= '0;
        end else if (w_out_acc) begin
            r_prev_hit  <= o_hit_total;
            r_prev_miss <= o_miss_total;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_way_index) &&
                                  $stable(o_set_index) && $stable(o_hit_total) &&
                                  $stable(o_miss_total)))
        else $error("stalled output word changed");

    a_totals_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (o_hit ? (w_hit_step && (o_miss_total == r_prev_miss))
                             : (w_miss_step && (o_hit_total == r_prev_hit))))
        else $error("hit or miss total did not follow the word sequence");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);
